@@ hdl/acic_pkg.sv @@
`timescale 1ns / 1ps

package acic_pkg;

  localparam int BYTE_W          = 8;
  localparam int VALUE_W         = 64;
  localparam int MAX_BYTES       = VALUE_W / BYTE_W;
  localparam int VALUE_BYTES_DEF = 8;
  localparam int CNT_W           = 4;
  localparam int IN_TDATA_W      = 72;   // value, content_byte
  localparam int OUT_TDATA_W     = 80;   // out_byte, decoded_value, too_long, pad
  localparam int OUT_PAD_W       = OUT_TDATA_W - BYTE_W - VALUE_W - 1;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_ENCODE  = 1'b0;
  localparam logic CMD_DECODE  = 1'b1;
  localparam logic KIND_ENC    = 1'b0;
  localparam logic KIND_DEC    = 1'b1;

  // classified item as held in the queue
  typedef struct packed {
    logic                 cmd;
    logic [VALUE_W-1:0]   aligned;   // encode: octets left-justified
    logic [CNT_W-1:0]     len;       // encode: octet count, 1..8
    logic [BYTE_W-1:0]    octet;     // decode: content octet
    logic                 last;      // decode: final octet
  } qent_t;

  typedef struct packed {
    logic                 kind;
    logic [BYTE_W-1:0]    out_byte;
    logic                 last;
    logic [VALUE_W-1:0]   value;
    logic                 too_long;
  } res_t;

  // sign-extend the low nb octets of u (nb in 1..8)
  function automatic logic [VALUE_W-1:0] sext_bytes(input logic [VALUE_W-1:0] u,
                                                     input logic [CNT_W-1:0] nb);
    logic [VALUE_W-1:0] r;
    logic               s;
    s = 1'b0;
    for (int i = 0; i < MAX_BYTES; i++) begin
      if (nb == CNT_W'(i + 1)) s = u[BYTE_W*i + BYTE_W - 1];
    end
    for (int i = 0; i < MAX_BYTES; i++) begin
      r[BYTE_W*i +: BYTE_W] = (CNT_W'(i) < nb) ? u[BYTE_W*i +: BYTE_W] : {BYTE_W{s}};
    end
    return r;
  endfunction

endpackage

@@ hdl/acic_front.sv @@
`timescale 1ns / 1ps

module acic_front #(
  parameter int VALUE_BYTES = acic_pkg::VALUE_BYTES_DEF
) (
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [acic_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // value, content_byte
  input  logic                          s_axis_tuser,  // command
  input  logic                          s_axis_tlast,
  input  logic                          q_full,
  output logic                          q_push,
  output acic_pkg::qent_t               q_entry
);
  import acic_pkg::*;

  localparam logic [CNT_W-1:0] TB = CNT_W'(VALUE_BYTES);

  logic [VALUE_W-1:0]   v;
  logic [MAX_BYTES-2:0] fits;
  logic [CNT_W-1:0]     n;
  logic [5:0]           sh;

  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;

  always_comb begin
    v = sext_bytes(s_axis_tdata[VALUE_W-1:0], TB);
    for (int i = 0; i < MAX_BYTES - 1; i++) begin
      fits[i] = (sext_bytes(v, CNT_W'(i + 1)) == v);
    end
    // shortest form within the type width
    n = TB;
    for (int i = MAX_BYTES - 2; i >= 0; i--) begin
      if (CNT_W'(i + 1) < TB && fits[i]) n = CNT_W'(i + 1);
    end
    sh = 6'({CNT_W'(MAX_BYTES) - n, 3'b000});

    q_entry.cmd     = s_axis_tuser;
    q_entry.aligned = v << sh;
    q_entry.len     = n;
    q_entry.octet   = s_axis_tdata[VALUE_W +: BYTE_W];
    q_entry.last    = s_axis_tlast;
  end

endmodule

@@ hdl/acic_queue.sv @@
`timescale 1ns / 1ps

module acic_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  acic_pkg::qent_t wr_entry,
  output logic            full,
  output logic            head_valid,
  output acic_pkg::qent_t head,
  input  logic            pop
);
  import acic_pkg::*;

  qent_t               mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !do_pop) count <= count + 1'b1;
      else if (!push && do_pop) count <= count - 1'b1;
    end
  end

endmodule

@@ hdl/acic_back.sv @@
`timescale 1ns / 1ps

module acic_back #(
  parameter int VALUE_BYTES = acic_pkg::VALUE_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             head_valid,
  input  acic_pkg::qent_t                  head,
  output logic                             pop,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [acic_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // out_byte, decoded_value, too_long
  output logic                             m_axis_tuser,  // result_kind
  output logic                             m_axis_tlast
);
  import acic_pkg::*;

  localparam int               ACC_W = BYTE_W * VALUE_BYTES;
  localparam logic [CNT_W-1:0] TB    = CNT_W'(VALUE_BYTES);

  logic [ACC_W-1:0]   acc, acc_next;
  logic [CNT_W-1:0]   dcount, dcount_next;
  logic [VALUE_W-1:0] sr, sr_next;
  logic [CNT_W-1:0]   left, left_next;
  logic               out_valid, out_valid_next;
  res_t               out_res, out_res_next;
  logic               advance;
  logic               emit;
  logic [ACC_W+BYTE_W-1:0] acc_wide;

  assign advance = !out_valid || m_axis_tready;

  always_comb begin
    acc_next       = acc;
    dcount_next    = dcount;
    sr_next        = sr;
    left_next      = left;
    out_res_next   = out_res;
    out_valid_next = out_valid;
    emit           = 1'b0;
    pop            = 1'b0;
    acc_wide       = {acc, head.octet};

    if (advance) begin
      if (left != '0) begin
        // draining an encode
        emit                  = 1'b1;
        out_res_next.kind     = KIND_ENC;
        out_res_next.out_byte = sr[VALUE_W-1 -: BYTE_W];
        out_res_next.last     = (left == CNT_W'(1));
        out_res_next.value    = '0;
        out_res_next.too_long = 1'b0;
        sr_next               = sr << BYTE_W;
        left_next             = left - 1'b1;
      end else if (head_valid) begin
        pop = 1'b1;
        if (head.cmd == CMD_ENCODE) begin
          emit                  = 1'b1;
          out_res_next.kind     = KIND_ENC;
          out_res_next.out_byte = head.aligned[VALUE_W-1 -: BYTE_W];
          out_res_next.last     = (head.len == CNT_W'(1));
          out_res_next.value    = '0;
          out_res_next.too_long = 1'b0;
          sr_next               = head.aligned << BYTE_W;
          left_next             = head.len - 1'b1;
        end else begin
          if (dcount < TB) begin
            acc_next    = acc_wide[ACC_W-1:0];
            dcount_next = dcount + 1'b1;
          end else begin
            dcount_next = CNT_W'(VALUE_BYTES + 1);
          end
          if (head.last) begin
            emit                  = 1'b1;
            out_res_next.kind     = KIND_DEC;
            out_res_next.out_byte = '0;
            out_res_next.last     = 1'b0;
            if (dcount_next > TB) begin
              out_res_next.value    = '0;
              out_res_next.too_long = 1'b1;
            end else begin
              // top bit of the first octet sits at bit 8*count-1 of the accumulator
              out_res_next.value    = sext_bytes(VALUE_W'(acc_next), dcount_next);
              out_res_next.too_long = 1'b0;
            end
            acc_next    = '0;
            dcount_next = '0;
          end
        end
      end
      out_valid_next = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      dcount    <= '0;
      left      <= '0;
      out_valid <= 1'b0;
    end else begin
      acc       <= acc_next;
      dcount    <= dcount_next;
      left      <= left_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    sr      <= sr_next;
    out_res <= out_res_next;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tlast  = out_res.last;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_res.too_long, out_res.value,
                          out_res.out_byte};

endmodule

@@ hdl/asn1_integer_content_codec_unit.sv @@
`timescale 1ns / 1ps
// Channel  Beat fields (tdata low bit up)             tuser        tlast
// s_axis   value[63:0], content_byte[71:64]           command      last_byte
// m_axis   out_byte[7:0], decoded_value[71:8],        result_kind  last
//          too_long[72], zero pad to 80 bits
//
// Encode: 1..VALUE_BYTES output octets per item, produced by the back end
// draining its shift register one octet a cycle while the output is not stalled.
// Decode: one content octet a cycle unless the output stalls; a result beat only on the final octet.
// A two-entry queue sits between the classifier and the back end; the output
// register frees the back end as soon as the beat is taken.
// rst (synchronous) clears the queue, encode drain count, decode count/accumulator and output valid.

module asn1_integer_content_codec_unit #(
  parameter int VALUE_BYTES = acic_pkg::VALUE_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [acic_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // value, content_byte
  input  logic                             s_axis_tuser,  // command
  input  logic                             s_axis_tlast,  // last_byte
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [acic_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // out_byte, decoded_value, too_long
  output logic                             m_axis_tuser,  // result_kind
  output logic                             m_axis_tlast   // last
);
  import acic_pkg::*;

  logic  q_full;
  logic  q_push;
  qent_t q_entry;
  logic  head_valid;
  qent_t head;
  logic  pop;

  acic_front #(
    .VALUE_BYTES(VALUE_BYTES)
  ) u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  acic_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_entry  (q_entry),
    .full      (q_full),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop)
  );

  acic_back #(
    .VALUE_BYTES(VALUE_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule
